// ----- rtl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared beat types, constants and helpers for the four-bone skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int NUM_ROWS       = 3;
  localparam int NUM_INFL       = 4;
  localparam int BONE_W         = 6;
  localparam int W3_W           = 19;
  localparam int PROD_W         = 51;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SKIN = 1'b1;

  localparam logic signed [W3_W-1:0] WEIGHT_ONE = W3_W'(32768);
  localparam logic signed [W3_W-1:0] WARN_LIMIT = -W3_W'(4);

  typedef struct packed {
    logic               action;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               is_point;
    logic [5:0]         bone_0;
    logic [5:0]         bone_1;
    logic [5:0]         bone_2;
    logic [5:0]         bone_3;
    logic [15:0]        weight_0;
    logic [15:0]        weight_1;
    logic [15:0]        weight_2;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               weight_warning;
  } lbs_out_t;

  typedef struct packed {
    logic signed [W3_W-1:0] w0;
    logic signed [W3_W-1:0] w1;
    logic signed [W3_W-1:0] w2;
    logic signed [W3_W-1:0] w3;
    logic                   warn;
  } lbs_wgt_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [71:0] x);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- rtl/lbs_ram.sv -----
// ----------------------------------------------------------------------------
// lbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lbs_bone_xform.sv -----
// ----------------------------------------------------------------------------
// lbs_bone_xform
// One bone's 3x4 transform: product stage, then row sum, round and saturate.
// ----------------------------------------------------------------------------
module lbs_bone_xform #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] m [lbs_pkg::WORDS_PER_BONE],
  input  logic               zero,
  input  logic               point,
  input  logic signed [31:0] v [3],
  output logic signed [31:0] row [lbs_pkg::NUM_ROWS]
);
  import lbs_pkg::*;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0] mm [WORDS_PER_BONE];
  logic signed [63:0] p_r [NUM_ROWS][3];
  logic signed [31:0] t_r [NUM_ROWS];
  logic               pt_r;
  logic signed [31:0] row_r [NUM_ROWS];
  logic signed [31:0] row_nxt [NUM_ROWS];

  always_comb begin
    for (int i = 0; i < WORDS_PER_BONE; i++) begin
      mm[i] = zero ? 32'sd0 : m[i];
    end
  end

  always_comb begin
    logic signed [65:0] s;
    logic signed [71:0] e;
    for (int r = 0; r < NUM_ROWS; r++) begin
      s = 66'(p_r[r][0]) + 66'(p_r[r][1]) + 66'(p_r[r][2]) + HALF;
      e = 72'(s >>> FRAC_BITS);
      if (pt_r) begin
        e = e + 72'(t_r[r]);
      end
      row_nxt[r] = sat_s32(e);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[r][c] <= 64'(mm[r*4+c]) * 64'(v[c]);
        end
        t_r[r]   <= mm[r*4+3];
        row_r[r] <= row_nxt[r];
      end
      pt_r <= point;
    end
  end

  assign row = row_r;

endmodule

// ----- rtl/lbs_blend.sv -----
// ----------------------------------------------------------------------------
// lbs_blend
// Weight the bone rows, sum the four influences, round and saturate.
// ----------------------------------------------------------------------------
module lbs_blend (
  input  logic              clk,
  input  logic              en,
  input  logic signed [31:0] row [lbs_pkg::NUM_INFL][lbs_pkg::NUM_ROWS],
  input  lbs_pkg::lbs_wgt_t wgt,
  output lbs_pkg::lbs_out_t res
);
  import lbs_pkg::*;

  logic signed [W3_W-1:0]   w [NUM_INFL];
  logic signed [PROD_W-1:0] prod_r [NUM_INFL][NUM_ROWS];
  logic                     warn_r;
  logic signed [31:0]       acc_nxt [NUM_ROWS];
  lbs_out_t                 res_r;

  assign w[0] = wgt.w0;
  assign w[1] = wgt.w1;
  assign w[2] = wgt.w2;
  assign w[3] = wgt.w3;

  always_comb begin
    logic signed [71:0] s;
    for (int r = 0; r < NUM_ROWS; r++) begin
      s = 72'(prod_r[0][r]) + 72'(prod_r[1][r]) + 72'(prod_r[2][r]) +
          72'(prod_r[3][r]) + 72'sd16384;
      acc_nxt[r] = sat_s32(s >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_INFL; k++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          prod_r[k][r] <= PROD_W'(row[k][r]) * PROD_W'(w[k]);
        end
      end
      warn_r               <= wgt.warn;
      res_r.out_x          <= acc_nxt[0];
      res_r.out_y          <= acc_nxt[1];
      res_r.out_z          <= acc_nxt[2];
      res_r.weight_warning <= warn_r;
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/linear_blend_vertex_skinning.sv -----
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Stages from input beat to result beat, in order: palette read, products,
// row sums, weighting, blend. Throughput: one beat per cycle; the whole
// pipe holds while the output register is full and not taken.
// Reset clears the stage valid bits only; the palette is undefined until
// written and needs no clearing pass.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
  parameter int NUM_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbs_pkg::lbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lbs_pkg::lbs_out_t out_data
);
  import lbs_pkg::*;

  localparam int AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

  logic                   en;
  logic                   acc_in;
  logic                   we;
  logic [BONE_W-1:0]      bsel [NUM_INFL];
  logic [4:0]             vld_r;
  logic [4:0]             vld_nxt;
  logic [31:0]            rd [NUM_INFL][WORDS_PER_BONE];
  logic signed [31:0]     m [NUM_INFL][WORDS_PER_BONE];
  logic signed [31:0]     row [NUM_INFL][NUM_ROWS];
  logic signed [31:0]     v_r [3];
  logic                   pt_r;
  logic [NUM_INFL-1:0]    zero_r;
  lbs_wgt_t               wgt_nxt;
  lbs_wgt_t               wgt1_r;
  lbs_wgt_t               wgt2_r;
  lbs_wgt_t               wgt3_r;

  assign en       = !vld_r[4] || out_ready;
  assign in_ready = en;
  assign acc_in   = in_valid && en;
  assign we       = acc_in && (in_data.action == ACT_LOAD) &&
                    (9'(in_data.bone_0) < 9'(NUM_BONES)) &&
                    (in_data.bone_1 < BONE_W'(WORDS_PER_BONE));

  assign bsel[0] = in_data.bone_0;
  assign bsel[1] = in_data.bone_1;
  assign bsel[2] = in_data.bone_2;
  assign bsel[3] = in_data.bone_3;

  always_comb begin
    wgt_nxt.w0   = W3_W'(signed'({1'b0, in_data.weight_0}));
    wgt_nxt.w1   = W3_W'(signed'({1'b0, in_data.weight_1}));
    wgt_nxt.w2   = W3_W'(signed'({1'b0, in_data.weight_2}));
    wgt_nxt.w3   = WEIGHT_ONE - wgt_nxt.w0 - wgt_nxt.w1 - wgt_nxt.w2;
    wgt_nxt.warn = (wgt_nxt.w3 <= WARN_LIMIT);
    vld_nxt      = {vld_r[3:0], acc_in && (in_data.action == ACT_SKIN)};
  end

  for (genvar k = 0; k < NUM_INFL; k++) begin : g_infl
    for (genvar c = 0; c < WORDS_PER_BONE; c++) begin : g_word
      lbs_ram #(.WIDTH(32), .DEPTH(NUM_BONES), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we && (in_data.bone_1 == BONE_W'(c))),
        .waddr (AW'(in_data.bone_0)),
        .wdata (in_data.vec_x),
        .re    (en),
        .raddr (AW'(bsel[k])),
        .rdata (rd[k][c])
      );
      assign m[k][c] = signed'(rd[k][c]);
    end

    lbs_bone_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
      .clk   (clk),
      .en    (en),
      .m     (m[k]),
      .zero  (zero_r[k]),
      .point (pt_r),
      .v     (v_r),
      .row   (row[k])
    );
  end

  lbs_blend u_blend (
    .clk (clk),
    .en  (en),
    .row (row),
    .wgt (wgt3_r),
    .res (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= in_data.vec_x;
      v_r[1] <= in_data.vec_y;
      v_r[2] <= in_data.vec_z;
      pt_r   <= in_data.is_point;
      for (int k = 0; k < NUM_INFL; k++) begin
        zero_r[k] <= (9'(bsel[k]) >= 9'(NUM_BONES));
      end
      wgt1_r <= wgt_nxt;
      wgt2_r <= wgt1_r;
      wgt3_r <= wgt2_r;
    end
  end

  assign out_valid = vld_r[4];

endmodule
